/* rtl/rpbf_pkg.sv */
// Shared constants and the pack565 function for the recursive pixel blur filter.
// No dependencies; imported by the top level.
package rpbf_pkg;

  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam int WEIGHT_W   = 12;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_BLUR_WEIGHT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLOR_MODE  = 1'b1;

  localparam logic [WEIGHT_W-1:0] BLUR_WEIGHT_RST = 12'd2048;

  // opcodes carried in tuser
  localparam logic OP_SEED   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  // color modes
  localparam logic MODE_RGB888 = 1'b0;
  localparam logic MODE_RGB565 = 1'b1;

  // per-channel ceilings in 565 mode (red, green, blue)
  localparam logic [CH_W-1:0] CH_MAX_565 [NUM_CH] = '{8'd31, 8'd63, 8'd31};

  function automatic logic [15:0] pack565(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                          logic [CH_W-1:0] b);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

endpackage

/* rtl/rpbf_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; used by the blur filter top level for the seed average.
module rpbf_div #(
  parameter int DW = 26,
  parameter int NW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [NW-1:0] rem_q;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          qbit;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign qbit  = (trial >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out at the top, shift quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], qbit};
      rem_q <= qbit ? diff[NW-1:0] : trial[NW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

/* rtl/recursive_pixel_blur_filter.sv */
// Three-channel one-pole recursive blur with seed averaging.
// Depends on rpbf_pkg (constants, pack565) and rpbf_div (seed average divider).
//
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tuser: opcode; tdata: red, green, blue (8b each)
//  m_axis    | out       | tdata: red_out, green_out, blue_out (8b each)
//  cfg       | in        | index 0 blur_weight (12b), index 1 color_mode (1b)
//
// A seed request completes at accept; a filter request passes accept, equal-word
// check, 7 steps of the shared multiplier and finish, or skips the steps on an
// equal-word match. The first filter request after seeding also runs the
// bit-serial seed-average divider once per channel.
// Reset clears sums, accumulators, seed count and last word; no clearing pass.
// A result waits in the output register; finish holds until that register frees.
module recursive_pixel_blur_filter #(
  parameter int MAX_SEED      = 64,
  parameter int FRACTION_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [23:0]                           s_axis_tdata,  // red, green, blue
  input  logic                                  s_axis_tuser,  // opcode
  // master stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [23:0]                           m_axis_tdata,  // red_out, green_out, blue_out
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [rpbf_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [rpbf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  import rpbf_pkg::*;

  localparam int FB    = FRACTION_BITS;
  localparam int SW    = CH_W + FB;                       // running sum width
  localparam int KW    = (FB + 1 > WEIGHT_W) ? FB + 1 : WEIGHT_W;
  localparam int CNT_W = $clog2(MAX_SEED + 1);
  localparam int ACC_W = $clog2(MAX_SEED * 255 + 1);
  localparam int DW    = ACC_W + FB;
  localparam int PW    = SW + KW;

  localparam logic [KW-1:0] ONE_FIX  = KW'(1) << FB;
  localparam logic [SW:0]   HALF_FIX = (SW + 1)'(1) << (FB - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [2:0] STEP_LAST = 3'd6;

  // configuration
  logic [WEIGHT_W-1:0] weight_q;
  logic                mode_q;

  // filter state
  logic [SW-1:0]    sum_q   [NUM_CH];
  logic [ACC_W-1:0] acc_q   [NUM_CH];
  logic [CNT_W-1:0] count_q;
  logic [15:0]      last_q;

  // sequencer
  logic [2:0] state_q, state_d;
  logic [1:0] chan_q;
  logic       div_run_q;
  logic [2:0] step_q;
  logic       bypass_q;

  // datapath
  logic [CH_W-1:0] px_in  [NUM_CH];
  logic [CH_W-1:0] px_q   [NUM_CH];
  logic [PW-1:0]   prod_q;
  logic [SW-1:0]   part_q;
  logic [CH_W-1:0] res    [NUM_CH];
  logic [CH_W-1:0] out_q  [NUM_CH];
  logic            out_valid_q;

  logic            in_fire;
  logic            mode565;
  logic [KW-1:0]   k_eff;
  logic [KW-1:0]   k_inv;
  logic [1:0]      mul_ch;
  logic [1:0]      wr_ch;
  logic [SW-1:0]   mul_a;
  logic [KW-1:0]   mul_b;
  logic [SW:0]     upd_sum;
  logic            out_free;
  logic            div_start;
  logic            div_done;
  logic [DW-1:0]   div_quot;

  assign mode565       = (mode_q == MODE_RGB565);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // mask the incoming channels to the active color format
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      px_in[c] = s_axis_tdata[CH_W*c +: CH_W];
      if (mode565) px_in[c] = px_in[c] & CH_MAX_565[c];
    end
  end

  // clamp the weight to one and form its complement
  assign k_eff = (KW'(weight_q) > ONE_FIX) ? ONE_FIX : KW'(weight_q);
  assign k_inv = ONE_FIX - k_eff;

  // shared multiplier operands: even steps sum*k, odd steps pixel*(1-k)
  assign mul_ch  = (step_q[2:1] == 2'd3) ? 2'd2 : step_q[2:1];
  assign wr_ch   = step_q[2:1] - 2'd1;
  assign mul_a   = step_q[0] ? SW'(px_q[mul_ch]) : sum_q[mul_ch];
  assign mul_b   = step_q[0] ? k_inv : k_eff;
  assign upd_sum = {1'b0, part_q} + {1'b0, prod_q[SW-1:0]};

  // result formatting: pass the pixel on a skip, else truncate in 888 mode, round and saturate in 565 mode
  always_comb begin
    logic [SW:0]   rnd;
    logic [CH_W:0] r565;
    for (int c = 0; c < NUM_CH; c++) begin
      rnd  = {1'b0, sum_q[c]} + HALF_FIX;
      r565 = rnd[FB +: CH_W + 1];
      if (bypass_q) begin
        res[c] = px_q[c];
      end else if (mode565) begin
        res[c] = (r565 > {1'b0, CH_MAX_565[c]}) ? CH_MAX_565[c] : r565[CH_W-1:0];
      end else begin
        res[c] = sum_q[c][FB +: CH_W];
      end
    end
  end

  assign div_start = (state_q == ST_DIV) && !div_run_q;

  rpbf_div #(
    .DW (DW),
    .NW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({acc_q[chan_q], {FB{1'b0}}}),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser == OP_FILTER) begin
          state_d = (count_q != '0) ? ST_DIV : ST_CHECK;
        end
      end
      ST_DIV: begin
        if (div_run_q && div_done && chan_q == 2'd2) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (mode565 && pack565(px_q[0], px_q[1], px_q[2]) == last_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_q == STEP_LAST) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= BLUR_WEIGHT_RST;
      mode_q   <= MODE_RGB888;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BLUR_WEIGHT: weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
        CFG_COLOR_MODE:  mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chan_q      <= '0;
      div_run_q   <= 1'b0;
      step_q      <= '0;
      bypass_q    <= 1'b0;
      count_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_q[c] <= '0;
        acc_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      // load the output register on finish, drop it once taken downstream
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          chan_q    <= '0;
          div_run_q <= 1'b0;
          step_q    <= '0;
          if (in_fire && s_axis_tuser == OP_SEED) begin
            // seed: accumulate until saturated, always drop the last word
            if (count_q < CNT_W'(MAX_SEED)) begin
              for (int c = 0; c < NUM_CH; c++) begin
                acc_q[c] <= acc_q[c] + ACC_W'(px_in[c]);
              end
              count_q <= count_q + CNT_W'(1);
            end
            last_q <= '0;
          end
        end
        ST_DIV: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            sum_q[chan_q] <= div_quot[SW-1:0];
            acc_q[chan_q] <= '0;
            div_run_q     <= 1'b0;
            chan_q        <= chan_q + 2'd1;
            if (chan_q == 2'd2) count_q <= '0;
          end
        end
        ST_CHECK: begin
          bypass_q <= mode565 && (pack565(px_q[0], px_q[1], px_q[2]) == last_q);
        end
        ST_MUL: begin
          step_q <= step_q + 3'd1;
          if (!step_q[0] && step_q != 3'd0) sum_q[wr_ch] <= upd_sum[SW-1:0];
        end
        ST_FIN: begin
          if (out_free && mode565 && !bypass_q) begin
            last_q <= pack565(res[0], res[1], res[2]);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int c = 0; c < NUM_CH; c++) px_q[c] <= px_in[c];
    end
    if (state_q == ST_MUL && step_q != STEP_LAST) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
      if (step_q[0]) part_q <= prod_q[FB +: SW];
    end
    if (state_q == ST_FIN && out_free) begin
      for (int c = 0; c < NUM_CH; c++) out_q[c] <= res[c];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

endmodule

/* verif/tb.sv */
// Self-checking testbench for recursive_pixel_blur_filter: seed averaging, recursive
// blur in both color modes, equal-word skip, seed saturation and stream backpressure.
// Depends on rtl/rpbf_pkg.sv, rtl/rpbf_div.sv and rtl/recursive_pixel_blur_filter.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpbf_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 8;
  localparam int FRAC          = 12;
  localparam int SEED_CAP      = 64;
  // worst request: seed-average divide plus the filter pass, with margin
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;

  // red sits in the lowest byte, matching the tdata layout
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata  = '0;   // red, green, blue
  logic                  s_axis_tuser  = 1'b0; // opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;         // red_out, green_out, blue_out
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // blur state mirrored from the block, reset values as after rst_ni
  longint unsigned chan_sum [3] = '{0, 0, 0};
  longint unsigned seed_sum [3] = '{0, 0, 0};
  int              seed_cnt     = 0;
  logic [15:0]     last_word    = '0;
  logic [11:0]     weight_reg   = BLUR_WEIGHT_RST;
  logic            mode_reg     = MODE_RGB888;

  pixel_t expected_pixels [$];
  int     mismatches   = 0;
  int     idle_pct     = 0;   // sender idle chance per cycle, percent
  int     stall_pct    = 0;   // receiver stall chance per cycle, percent
  bit     hold_off_req = 1'b0;
  int     quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  recursive_pixel_blur_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Advance the mirrored blur state by one accepted request and queue the
  // pixel it must produce, if any.
  task automatic predict_blur(input logic op, input pixel_t p);
    logic [CH_W-1:0] px  [3];
    longint unsigned res [3];
    longint unsigned k, kinv;
    pixel_t          want;
    logic [15:0]     word;
    px = '{p.red, p.green, p.blue};
    if (mode_reg == MODE_RGB565) begin
      for (int i = 0; i < 3; i++) px[i] &= CH_MAX_565[i];
    end
    // seeding: accumulate until the cap, always clear the last word
    if (op == OP_SEED) begin
      if (seed_cnt < SEED_CAP) begin
        for (int i = 0; i < 3; i++) seed_sum[i] += px[i];
        seed_cnt++;
      end
      last_word = '0;
      return;
    end
    // first filter request after seeding loads the seed average
    if (seed_cnt != 0) begin
      for (int i = 0; i < 3; i++) begin
        chan_sum[i] = (seed_sum[i] << FRAC) / longint'(seed_cnt);
        seed_sum[i] = 0;
      end
      seed_cnt = 0;
    end
    word = {px[0][4:0], px[1][5:0], px[2][4:0]};
    // equal-word skip: pass the pixel through, leave the sums alone
    if (mode_reg == MODE_RGB565 && word == last_word) begin
      want = {px[2], px[1], px[0]};
      expected_pixels.push_back(want);
      return;
    end
    k    = weight_reg;
    kinv = (longint'(1) << FRAC) - k;
    for (int i = 0; i < 3; i++) begin
      chan_sum[i] = ((chan_sum[i] * k) >> FRAC) + px[i] * kinv;
      if (mode_reg == MODE_RGB565) begin
        res[i] = (chan_sum[i] + (longint'(1) << (FRAC - 1))) >> FRAC;
        if (res[i] > CH_MAX_565[i]) res[i] = CH_MAX_565[i];
      end else begin
        res[i] = chan_sum[i] >> FRAC;
        if (res[i] > 255) res[i] = 255;
      end
    end
    want = {res[2][7:0], res[1][7:0], res[0][7:0]};
    if (mode_reg == MODE_RGB565)
      last_word = {want.red[4:0], want.green[5:0], want.blue[4:0]};
    expected_pixels.push_back(want);
  endtask

  // Offer one request from a falling edge; return on the falling edge after
  // acceptance with tvalid still high, so back-to-back requests need no gap.
  task automatic send_request(input logic op, input pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_blur(op, p);
    @(negedge clk_i);
  endtask

  // Drop tvalid and hold until every queued pixel has come out.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_BLUR_WEIGHT) weight_reg = val[11:0];
    else mode_reg = val[0];
    @(negedge clk_i);
  endtask

  // Registers change only with the block idle: drain, let any trailing seed
  // or divide settle, then write both.
  task automatic apply_settings(input logic [11:0] weight, input logic mode);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_BLUR_WEIGHT, weight);
    write_reg(CFG_COLOR_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    cfg_we_i <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel(input bit narrow);
    pixel_t p;
    if (narrow) begin
      p.red   = 8'($urandom_range(31));
      p.green = 8'($urandom_range(63));
      p.blue  = 8'($urandom_range(31));
    end else begin
      p = 24'($urandom());
    end
    return p;
  endfunction

  // Truncating 8-bit mode: filter with no seeds, channel extremes, seed average.
  task automatic test_rgb888_basics();
    apply_settings(BLUR_WEIGHT_RST, MODE_RGB888);
    send_request(OP_FILTER, '{8'd255, 8'd255, 8'd255});
    send_request(OP_FILTER, '{8'd0, 8'd0, 8'd0});
    send_request(OP_SEED,   '{8'd128, 8'd0, 8'd255});
    send_request(OP_SEED,   '{8'd3, 8'd2, 8'd1});
    send_request(OP_FILTER, '{8'd30, 8'd20, 8'd10});
    send_request(OP_FILTER, '{8'd255, 8'd0, 8'd255});
  endtask

  // 565 mode: masking of wide channels, rounding, equal-word skip and the
  // seed clearing the last word, at both weight extremes and at half weight.
  task automatic test_rgb565_modes();
    apply_settings(12'd0, MODE_RGB565);
    send_request(OP_FILTER, '{8'd0, 8'd0, 8'd0});       // matches cleared last word
    send_request(OP_FILTER, '{8'd255, 8'd255, 8'd255}); // masked to the ceilings
    send_request(OP_FILTER, '{8'd31, 8'd63, 8'd31});    // repeat of the last word
    send_request(OP_SEED,   '{8'd9, 8'd40, 8'd17});
    send_request(OP_FILTER, '{8'd31, 8'd63, 8'd31});
    apply_settings(12'd4095, MODE_RGB565);
    send_request(OP_FILTER, '{8'd7, 8'd6, 8'd5});
    send_request(OP_FILTER, '{8'd224, 8'd192, 8'd224});
    send_request(OP_SEED,   '{8'd255, 8'd255, 8'd255});
    send_request(OP_FILTER, '{8'd0, 8'd0, 8'd0});       // seed load, then skip
    apply_settings(12'd2048, MODE_RGB565);
    send_request(OP_FILTER, '{8'd1, 8'd1, 8'd1});
    send_request(OP_FILTER, '{8'd1, 8'd1, 8'd1});
  endtask

  // Push past the seed cap; extra seeds must not move the average.
  task automatic test_seed_saturation();
    apply_settings(12'd3000, MODE_RGB888);
    repeat (SEED_CAP + 6) send_request(OP_SEED, rand_pixel(1'b0));
    send_request(OP_FILTER, '{8'd0, 8'd0, 8'd0});
    send_request(OP_FILTER, rand_pixel(1'b0));
  endtask

  // Mostly seed runs followed by filter runs, some with a steady pixel so the
  // 565 skip can trigger; the rest single requests of random kind.
  task automatic test_random_traffic();
    int     idle_tab  [4] = '{0, 71, 0, 27};
    int     stall_tab [4] = '{0, 0, 71, 27};
    int     sent, nseed, nfilt;
    bit     narrow, steady;
    logic [11:0] weight;
    pixel_t base;
    for (int phase = 0; phase < 4; phase++) begin
      for (int sub = 0; sub < 2; sub++) begin
        case ($urandom_range(3))
          0:       weight = 12'd0;
          1:       weight = 12'd4095;
          default: weight = 12'($urandom_range(4095));
        endcase
        apply_settings(weight, 1'($urandom_range(1)));
        idle_pct  = idle_tab[phase];
        stall_pct = stall_tab[phase];
        sent      = 0;
        while (sent < 60) begin
          narrow = (mode_reg == MODE_RGB565) && ($urandom_range(7) != 0);
          if ($urandom_range(9) == 0) begin
            send_request(1'($urandom_range(1)), rand_pixel(1'b0));
            sent++;
          end else begin
            nseed = ($urandom_range(19) == 0) ? $urandom_range(68, 62) : $urandom_range(4);
            repeat (nseed) send_request(OP_SEED, rand_pixel(narrow));
            nfilt  = $urandom_range(8, 1);
            steady = ($urandom_range(2) == 0);
            base   = rand_pixel(narrow);
            repeat (nfilt) send_request(OP_FILTER, steady ? base : rand_pixel(narrow));
            sent += nseed + nfilt;
          end
        end
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // Hold the receiver off long enough for the block to fill and stall its
  // input, then pause the sender until every result is out before resuming.
  task automatic test_backpressure();
    apply_settings(12'd1024, MODE_RGB888);
    hold_off_req = 1'b1;
    repeat (30) send_request(OP_FILTER, rand_pixel(1'b0));
    wait_drain();
    repeat (3) send_request(OP_SEED, rand_pixel(1'b0));
    repeat (4) send_request(OP_FILTER, rand_pixel(1'b0));
  endtask

  initial begin : run_tests
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_rgb888_basics();
    test_rgb565_modes();
    test_seed_saturation();
    test_random_traffic();
    test_backpressure();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Drive tready from the falling edge; on a hold-off request keep it low
  // for a fixed stretch counted here.
  initial begin : drive_ready
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every accepted result, channel by channel, with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    pixel_t got, want;
    string  chan_name [3];
    chan_name = '{"red", "green", "blue"};
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: result %h with none expected", $time, got);
      end else begin
        want = expected_pixels.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got[i*CH_W +: CH_W] !== want[i*CH_W +: CH_W]) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, chan_name[i],
                     want[i*CH_W +: CH_W], got[i*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  // End the run if neither side moves and no register is written for too long.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/rpbf_pkg.sv
rtl/rpbf_div.sv
rtl/recursive_pixel_blur_filter.sv
verif/tb.sv
